/* design/lcdseq_pkg.sv */
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Types, constants and the start-up nibble table for the LCD nibble sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  localparam int unsigned SampleWidth = 12;
  localparam int unsigned StartupLen  = 38;
  localparam int unsigned ScaleCenti  = 330;
  localparam int unsigned IdxWidth    = 6;
  localparam int unsigned SeqDepth    = 8;
  localparam logic [7:0]  CursorReset = 8'h8B;
  localparam logic [7:0]  ShortCmdA   = 8'h30;
  localparam logic [7:0]  ShortCmdB   = 8'h20;
  localparam logic [3:0]  DigitHigh   = 4'h3;

  localparam logic KindStartup = 1'b0;
  localparam logic KindSample  = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic [SampleWidth-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       register_select;
    logic       last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIGITS,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic build;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_step;
    logic out_free;
  } dp_status_t;

  // Returns {register_select, nibble} for one step of the start-up sequence.
  function automatic logic [4:0] startup_entry(logic [IdxWidth-1:0] idx);
    logic [4:0] e;
    case (idx)
      6'd0:    e = {1'b0, 4'h3};
      6'd1:    e = {1'b0, 4'h3};
      6'd2:    e = {1'b0, 4'h3};
      6'd3:    e = {1'b0, 4'h2};
      6'd4:    e = {1'b0, 4'h2};
      6'd5:    e = {1'b0, 4'h8};
      6'd6:    e = {1'b0, 4'h0};
      6'd7:    e = {1'b0, 4'hC};
      6'd8:    e = {1'b0, 4'h0};
      6'd9:    e = {1'b0, 4'h1};
      6'd10:   e = {1'b0, 4'h8};
      6'd11:   e = {1'b0, 4'h0};
      6'd12:   e = {1'b0, 4'h0};
      6'd13:   e = {1'b0, 4'h6};
      6'd14:   e = {1'b0, 4'h8};
      6'd15:   e = {1'b0, 4'h0};
      6'd16:   e = {1'b1, 4'h4};
      6'd17:   e = {1'b1, 4'h2};
      6'd18:   e = {1'b1, 4'h6};
      6'd19:   e = {1'b1, 4'hF};
      6'd20:   e = {1'b1, 4'h6};
      6'd21:   e = {1'b1, 4'h4};
      6'd22:   e = {1'b1, 4'h7};
      6'd23:   e = {1'b1, 4'h9};
      6'd24:   e = {1'b1, 4'h2};
      6'd25:   e = {1'b1, 4'h0};
      6'd26:   e = {1'b1, 4'h5};
      6'd27:   e = {1'b1, 4'h4};
      6'd28:   e = {1'b1, 4'h6};
      6'd29:   e = {1'b1, 4'h5};
      6'd30:   e = {1'b1, 4'h6};
      6'd31:   e = {1'b1, 4'hD};
      6'd32:   e = {1'b1, 4'h7};
      6'd33:   e = {1'b1, 4'h0};
      6'd34:   e = {1'b1, 4'h3};
      6'd35:   e = {1'b1, 4'hA};
      6'd36:   e = {1'b1, 4'h2};
      6'd37:   e = {1'b1, 4'h0};
      default: e = 5'h00;
    endcase
    return e;
  endfunction

endpackage

/* design/lcdseq_ctrl.sv */
// ----------------------------------------------------------------------------
// lcdseq_ctrl
// Controller state machine: takes items, orders digit build and nibble emission.
// ----------------------------------------------------------------------------
module lcdseq_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_kind_i,
  input  lcdseq_pkg::dp_status_t status_i,
  output logic                   in_ready_o,
  output lcdseq_pkg::ctrl_cmd_t  cmd_o
);

  lcdseq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcdseq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lcdseq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_kind_i == lcdseq_pkg::KindSample) ? lcdseq_pkg::ST_DIGITS
                                                          : lcdseq_pkg::ST_EMIT;
        end
      end
      lcdseq_pkg::ST_DIGITS: begin
        state_d = lcdseq_pkg::ST_EMIT;
      end
      lcdseq_pkg::ST_EMIT: begin
        if (status_i.out_free && status_i.last_step) begin
          state_d = lcdseq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lcdseq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      lcdseq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      lcdseq_pkg::ST_DIGITS: begin
        cmd_o.build = 1'b1;
      end
      lcdseq_pkg::ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == lcdseq_pkg::ST_DIGITS || state_q == lcdseq_pkg::ST_EMIT))
    else $error("load did not leave idle");

  a_build_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.build |=> state_q == lcdseq_pkg::ST_EMIT)
    else $error("digit build not followed by emission");

endmodule

/* design/lcdseq_dp.sv */
// ----------------------------------------------------------------------------
// lcdseq_dp
// Datapath: sample scaling, decimal digits, nibble sequence and output register.
// ----------------------------------------------------------------------------
module lcdseq_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lcdseq_pkg::in_t        in_data_i,
  input  logic                   cfg_valid_i,
  input  logic [7:0]             cfg_data_i,
  input  logic                   out_ready_i,
  input  lcdseq_pkg::ctrl_cmd_t  cmd_i,
  output lcdseq_pkg::dp_status_t status_o,
  output logic                   out_valid_o,
  output lcdseq_pkg::out_t       out_data_o
);

  localparam int unsigned Sw     = lcdseq_pkg::SampleWidth;
  localparam int unsigned Pw     = Sw + 9;
  localparam int unsigned Iw     = lcdseq_pkg::IdxWidth;

  logic [7:0]      cursor_q;
  logic            kind_q;
  logic [8:0]      value_q;
  logic [Iw-1:0]   idx_q;
  logic [Iw-1:0]   len_q;
  logic [1:0]      base_q;
  logic [3:0]      seq_q [lcdseq_pkg::SeqDepth];
  logic            out_valid_q;
  lcdseq_pkg::out_t out_q;

  logic [Pw-1:0]   product;
  logic [1:0]      hundreds;
  logic [8:0]      hund_sub;
  logic [6:0]      rem;
  logic [13:0]     tens_prod;
  logic [3:0]      tens;
  logic [3:0]      ones;
  logic [1:0]      num_dig;
  logic [1:0]      base;
  logic            short_cmd;
  logic [3:0]      dig_nib [6];
  logic [3:0]      seq_d [lcdseq_pkg::SeqDepth];
  logic [3:0]      pos;
  logic [2:0]      offset;
  logic [4:0]      rom_entry;
  lcdseq_pkg::out_t emit_data;
  logic            last_step;

  assign product = Pw'(in_data_i.sample) * Pw'(lcdseq_pkg::ScaleCenti);

  always_comb begin
    if (value_q >= 9'd300) begin
      hundreds = 2'd3;
      hund_sub = 9'd300;
    end else if (value_q >= 9'd200) begin
      hundreds = 2'd2;
      hund_sub = 9'd200;
    end else if (value_q >= 9'd100) begin
      hundreds = 2'd1;
      hund_sub = 9'd100;
    end else begin
      hundreds = 2'd0;
      hund_sub = 9'd0;
    end
    rem       = 7'(value_q - hund_sub);
    tens_prod = 14'(rem) * 14'd103;
    tens      = tens_prod[13:10];
    ones      = 4'(rem - 7'(tens) * 7'd10);
    if (value_q >= 9'd100) begin
      num_dig = 2'd3;
    end else if (value_q >= 9'd10) begin
      num_dig = 2'd2;
    end else begin
      num_dig = 2'd1;
    end
  end

  always_comb begin
    short_cmd  = (cursor_q == lcdseq_pkg::ShortCmdA) || (cursor_q == lcdseq_pkg::ShortCmdB);
    base       = short_cmd ? 2'd1 : 2'd2;
    offset     = 3'd6 - {num_dig, 1'b0};
    dig_nib[0] = lcdseq_pkg::DigitHigh;
    dig_nib[1] = {2'b00, hundreds};
    dig_nib[2] = lcdseq_pkg::DigitHigh;
    dig_nib[3] = tens;
    dig_nib[4] = lcdseq_pkg::DigitHigh;
    dig_nib[5] = ones;
    for (int i = 0; i < lcdseq_pkg::SeqDepth; i++) begin
      pos = 4'(i) - 4'(base) + 4'(offset);
      if (4'(i) == 4'd0) begin
        seq_d[i] = cursor_q[7:4];
      end else if (4'(i) < 4'(base)) begin
        seq_d[i] = cursor_q[3:0];
      end else if (pos < 4'd6) begin
        seq_d[i] = dig_nib[pos[2:0]];
      end else begin
        seq_d[i] = 4'h0;
      end
    end
  end

  always_comb begin
    rom_entry = lcdseq_pkg::startup_entry(idx_q);
    last_step = (idx_q == len_q - Iw'(1));
    if (kind_q == lcdseq_pkg::KindSample) begin
      emit_data.nibble          = seq_q[idx_q[2:0]];
      emit_data.register_select = (idx_q >= Iw'(base_q));
    end else begin
      emit_data.nibble          = rom_entry[3:0];
      emit_data.register_select = rom_entry[4];
    end
    emit_data.last = last_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= lcdseq_pkg::CursorReset;
      out_valid_q <= 1'b0;
      kind_q      <= lcdseq_pkg::KindStartup;
      idx_q       <= '0;
      len_q       <= '0;
      base_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        cursor_q <= cfg_data_i;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        kind_q <= in_data_i.kind;
        idx_q  <= '0;
        len_q  <= Iw'(lcdseq_pkg::StartupLen);
      end else if (cmd_i.build) begin
        len_q  <= Iw'(base) + Iw'({num_dig, 1'b0});
        base_q <= base;
      end else if (cmd_i.emit && !last_step) begin
        idx_q <= idx_q + Iw'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= 9'(product >> Sw);
    end
    if (cmd_i.build) begin
      seq_q <= seq_d;
    end
    if (cmd_i.emit) begin
      out_q <= emit_data;
    end
  end

  assign status_o.last_step = last_step;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && last_step |=> out_valid_q && out_q.last)
    else $error("final nibble not marked last");

  a_sample_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.build |=> (len_q >= Iw'(3) && len_q <= Iw'(lcdseq_pkg::SeqDepth)))
    else $error("sample burst length out of range");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> idx_q < len_q)
    else $error("step index beyond burst length");

endmodule

/* design/lcd_nibble_display_sequencer.sv */
// ----------------------------------------------------------------------------
// lcd_nibble_display_sequencer
// Turns start-up and sample items into 4-bit character-LCD nibble transfers.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in       input      in_valid/ready     lcdseq_pkg::in_t (kind, sample)
// out      output     out_valid/ready    lcdseq_pkg::out_t (nibble, rs, last)
// cfg      input      cfg_valid/ready    8-bit cursor command
//
// A start-up item is loaded from idle and then emits 38 nibbles, one per cycle while the output is not stalled.
// A sample item is scaled on load, then has its digits built, and then emits 3 to 8 nibbles.
// The single output register limits emission to one nibble per cycle.
// Reset returns the controller to idle and sets the cursor command to 0x8B.
// A stalled output holds the sequencer; the next item is taken once the last
// nibble of the current item sits in the output register.
// ----------------------------------------------------------------------------
module lcd_nibble_display_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lcdseq_pkg::in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lcdseq_pkg::out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [7:0]       cfg_data_i
);

  lcdseq_pkg::ctrl_cmd_t  cmd;
  lcdseq_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  lcdseq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  lcdseq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
